// File: src/wsrt_pkg.sv
// Package for the weak slot reference count table.
// Holds transaction structs, operation/status/action codes and the
// controller/datapath command and status structs. No dependencies.
package wsrt_pkg;

   localparam int HANDLE_BITS = 9;
   localparam int GROUP_SIZE  = 16;
   localparam int GROUP_LOW_BITS = 4;

   localparam logic [1:0] KIND_CREATE     = 2'd0;
   localparam logic [1:0] KIND_ADD_REF    = 2'd1;
   localparam logic [1:0] KIND_DETACH_MST = 2'd2;
   localparam logic [1:0] KIND_DETACH_REF = 2'd3;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_BUSY  = 3'd1;
   localparam logic [2:0] ST_FULL  = 3'd2;
   localparam logic [2:0] ST_BAD   = 3'd3;
   localparam logic [2:0] ST_DEAD  = 3'd4;
   localparam logic [2:0] ST_MAX   = 3'd5;
   localparam logic [2:0] ST_NOREF = 3'd6;

   localparam logic [1:0] ACT_NONE  = 2'd0;
   localparam logic [1:0] ACT_ARMED = 2'd1;
   localparam logic [1:0] ACT_FIRED = 2'd2;

   typedef struct packed {
      logic [1:0]             kind;
      logic [HANDLE_BITS-1:0] slot_handle;
      logic                   has_signal;
   } req_type;

   typedef struct packed {
      logic [HANDLE_BITS-1:0] handle_out;
      logic [2:0]             status;
      logic [1:0]             signal_action;
      logic                   slot_freed;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;   // capture request transaction
      logic read;   // read slot memory, register group encodings
      logic exec;   // commit update and load result register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;
   } stat_type;

endpackage

// File: src/wsrt_ctrl.sv
// Controller state machine for the weak slot reference count table.
// Sequences accept, read and execute phases. Depends on wsrt_pkg.
module wsrt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  wsrt_pkg::stat_type stat,
   output wsrt_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_READ = 3'b010,
      S_EXEC = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      accept;
   logic      exec_fire;

   assign exec_fire = (state_ff == S_EXEC) && stat.out_free;
   assign req_stall = !((state_ff == S_IDLE) || exec_fire);
   assign accept    = req_valid && !req_stall;

   assign cmd.load = accept;
   assign cmd.read = (state_ff == S_READ);
   assign cmd.exec = exec_fire;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_READ;
         end
         S_READ: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (exec_fire) state_in = accept ? S_READ : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// File: src/wsrt_datapath.sv
// Datapath for the weak slot reference count table: acquired flags,
// grouped free-slot encoder, alive/count memory, result register.
// Depends on wsrt_pkg.
module wsrt_datapath #(
   parameter int NUM_SLOTS  = 256,
   parameter int COUNT_BITS = 14
) (
   input  logic               clock,
   input  logic               reset,
   input  wsrt_pkg::cmd_type  cmd,
   output wsrt_pkg::stat_type stat,
   input  wsrt_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output wsrt_pkg::rsp_type  rsp_data
);

   localparam int SLOT_BITS  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int NUM_GROUPS = (NUM_SLOTS + wsrt_pkg::GROUP_SIZE - 1) / wsrt_pkg::GROUP_SIZE;
   localparam int GROUP_BITS = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
   localparam int PAD_BITS   = NUM_GROUPS * wsrt_pkg::GROUP_SIZE;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   wsrt_pkg::req_type req_ff;
   wsrt_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [NUM_SLOTS-1:0] acquired_ff, acquired_in;

   logic [PAD_BITS-1:0]                      free_pad;
   logic [NUM_GROUPS-1:0]                    grp_any_ff, grp_any_in;
   logic [wsrt_pkg::GROUP_LOW_BITS-1:0]      grp_low_ff [NUM_GROUPS];
   logic [wsrt_pkg::GROUP_LOW_BITS-1:0]      grp_low_in [NUM_GROUPS];

   logic [COUNT_BITS:0] slot_mem [NUM_SLOTS];
   logic [COUNT_BITS:0] slot_rd_ff;

   logic [SLOT_BITS-1:0]  slot_idx;
   logic                  in_range;
   logic                  handle_ok;
   logic                  alive_rd;
   logic [COUNT_BITS-1:0] count_rd;

   logic [GROUP_BITS-1:0] sel_grp;
   logic                  any_free;
   logic [SLOT_BITS-1:0]  free_idx;

   logic                  mem_we;
   logic [SLOT_BITS-1:0]  wr_idx;
   logic [COUNT_BITS:0]   wr_word;
   logic                  set_acq;
   logic                  clr_acq;
   wsrt_pkg::rsp_type     result;

   assign stat.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_ff;

   assign in_range  = (req_ff.slot_handle != '0) && (32'(req_ff.slot_handle) <= NUM_SLOTS);
   assign slot_idx  = SLOT_BITS'(req_ff.slot_handle - wsrt_pkg::HANDLE_BITS'(1));
   assign handle_ok = in_range ? acquired_ff[slot_idx] : 1'b0;
   assign alive_rd  = slot_rd_ff[COUNT_BITS];
   assign count_rd  = slot_rd_ff[COUNT_BITS-1:0];

   // per-group lowest free slot
   always_comb begin
      free_pad = '0;
      free_pad[NUM_SLOTS-1:0] = ~acquired_ff;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         grp_any_in[g] = |free_pad[g*wsrt_pkg::GROUP_SIZE +: wsrt_pkg::GROUP_SIZE];
         grp_low_in[g] = '0;
         for (int b = wsrt_pkg::GROUP_SIZE - 1; b >= 0; b--) begin
            if (free_pad[g*wsrt_pkg::GROUP_SIZE + b])
               grp_low_in[g] = wsrt_pkg::GROUP_LOW_BITS'(b);
         end
      end
   end

   always_comb begin
      sel_grp = '0;
      for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) sel_grp = GROUP_BITS'(g);
      end
      any_free = |grp_any_ff;
      free_idx = SLOT_BITS'({sel_grp, grp_low_ff[sel_grp]});
   end

   always_comb begin
      result  = '0;
      mem_we  = 1'b0;
      wr_idx  = slot_idx;
      wr_word = slot_rd_ff;
      set_acq = 1'b0;
      clr_acq = 1'b0;
      case (req_ff.kind)
         wsrt_pkg::KIND_CREATE: begin
            if (req_ff.slot_handle != '0) begin
               result.status = wsrt_pkg::ST_BUSY;
            end else if (!any_free) begin
               result.status = wsrt_pkg::ST_FULL;
            end else begin
               mem_we  = 1'b1;
               wr_idx  = free_idx;
               wr_word = {1'b1, {COUNT_BITS{1'b0}}};
               set_acq = 1'b1;
               result.handle_out = wsrt_pkg::HANDLE_BITS'({1'b0, free_idx} + 1'b1);
               result.signal_action = req_ff.has_signal ? wsrt_pkg::ACT_ARMED
                                                        : wsrt_pkg::ACT_NONE;
            end
         end
         wsrt_pkg::KIND_ADD_REF: begin
            if (req_ff.slot_handle == '0) begin
               result.status = wsrt_pkg::ST_OK;
            end else if (!handle_ok) begin
               result.status = wsrt_pkg::ST_BAD;
            end else if (count_rd == COUNT_MAX) begin
               result.status = wsrt_pkg::ST_MAX;
            end else begin
               mem_we  = 1'b1;
               wr_word = {alive_rd, count_rd + 1'b1};
               result.handle_out = req_ff.slot_handle;
            end
         end
         wsrt_pkg::KIND_DETACH_MST: begin
            if (!handle_ok) begin
               result.status = wsrt_pkg::ST_BAD;
            end else if (!alive_rd) begin
               result.status = wsrt_pkg::ST_DEAD;
            end else begin
               mem_we  = 1'b1;
               wr_word = {1'b0, count_rd};
               clr_acq = (count_rd == '0);
               result.slot_freed = (count_rd == '0);
               result.handle_out = req_ff.slot_handle;
               result.signal_action = req_ff.has_signal ? wsrt_pkg::ACT_FIRED
                                                        : wsrt_pkg::ACT_NONE;
            end
         end
         wsrt_pkg::KIND_DETACH_REF: begin
            if (!handle_ok) begin
               result.status = wsrt_pkg::ST_BAD;
            end else if (count_rd == '0) begin
               result.status = wsrt_pkg::ST_NOREF;
            end else begin
               mem_we  = 1'b1;
               wr_word = {alive_rd, count_rd - 1'b1};
               clr_acq = !alive_rd && (count_rd == COUNT_BITS'(1));
               result.slot_freed = !alive_rd && (count_rd == COUNT_BITS'(1));
               result.handle_out = req_ff.slot_handle;
            end
         end
         default: begin
            result = '0;
         end
      endcase
   end

   always_comb begin
      acquired_in = acquired_ff;
      if (cmd.exec && set_acq) acquired_in[wr_idx] = 1'b1;
      if (cmd.exec && clr_acq) acquired_in[wr_idx] = 1'b0;
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.exec) begin
         rsp_in       = result;
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acquired_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acquired_ff  <= acquired_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (cmd.load) req_ff <= req_data;
      if (cmd.read) begin
         grp_any_ff <= grp_any_in;
         grp_low_ff <= grp_low_in;
      end
   end

   // alive/count memory; entries are read for any request, but only used for acquired slots
   always_ff @(posedge clock) begin
      if (cmd.read) slot_rd_ff <= slot_mem[slot_idx];
      if (cmd.exec && mem_we) slot_mem[wr_idx] <= wr_word;
   end

endmodule

// File: src/weak_slot_refcount_table.sv
// Weak slot reference count table: allocates slots and tracks master/reference lifetimes.
// A request is registered on acceptance, the read phase registers the alive/count memory word
// and group encodings, and the execute phase, held while the output stalls, loads the result
// register. A new request is accepted only as the previous one executes, since the memory read
// precedes its write-back; the output register holds one result. Reset clears acquired flags
// and control; the count memory needs no clear. Depends on wsrt_pkg, wsrt_ctrl, wsrt_datapath.
module weak_slot_refcount_table #(
   parameter int NUM_SLOTS  = 256,
   parameter int COUNT_BITS = 14
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  wsrt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output wsrt_pkg::rsp_type rsp_data
);

   wsrt_pkg::cmd_type  cmd;
   wsrt_pkg::stat_type stat;

   wsrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   wsrt_datapath #(
      .NUM_SLOTS  (NUM_SLOTS),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
